/* src/lfcp_pkg.sv */
// ============================================================================
// LED frame command parser package
// Shared byte codes, command and result codes, and default sizes.
// ============================================================================
package lfcp_pkg;

    // Default number of pixels in the frame
    localparam int PIXEL_COUNT_DEF = 12;
    // Default depth of the command queue between front and back
    localparam int CMD_DEPTH_DEF   = 4;

    // Received byte codes
    localparam logic [7:0] COLOR_MAX    = 8'd200;
    localparam logic [7:0] BYTE_SHOW    = 8'hFF;
    localparam logic [7:0] BYTE_BLACK   = 8'hFE;
    localparam logic [7:0] BYTE_DELAY   = 8'hFD;
    localparam logic [7:0] BYTE_CONNECT = 8'hFC;

    // Command codes passed from the front to the back
    localparam int OP_W = 3;
    typedef enum logic [OP_W-1:0] {
        OP_WRITE      = 3'd0,
        OP_WRITE_SHOW = 3'd1,
        OP_SHOW       = 3'd2,
        OP_BLACK      = 3'd3,
        OP_ECHO       = 3'd4,
        OP_ACK        = 3'd5
    } op_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_DELAY = 2'd1,
        KIND_ACK   = 2'd2
    } kind_t;

endpackage

/* src/led_frame_command_parser.sv */
// ============================================================================
// LED frame command parser
// Top level: byte parser, command queue and frame engine.
// ============================================================================
// Bytes enter through a queue-style port (push/full) and results leave
// through another (empty/pop). The parser takes one byte per cycle while the
// command queue has room. A frame emission (end of frame data, show, or black)
// is played out by the frame engine pixel by pixel: a registered frame store
// read, then a load of the output register, which waits while the output item
// is held. The frame store needs no clearing pass: per-entry written marks
// make unwritten channels read as zero right after reset.
module led_frame_command_parser
    import lfcp_pkg::*;
#(
    parameter int PIXEL_COUNT = PIXEL_COUNT_DEF,
    parameter int CMD_DEPTH   = CMD_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] rx_byte,
    input  logic       push,
    output logic       full,
    output logic [1:0] kind,
    output logic [3:0] pixel_index,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue,
    output logic [7:0] host_byte,
    output logic [7:0] delay_units,
    output logic       last,
    output logic       empty,
    input  logic       pop
);

    localparam int PIX_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int CMD_W = OP_W + PIX_W + 2 + 8;

    logic             cmd_push;
    logic [CMD_W-1:0] cmd_wdata;
    logic             cmd_full;
    logic             cmd_pop;
    logic [CMD_W-1:0] cmd_rdata;
    logic             cmd_empty;

    // Parse bytes into commands
    lfcp_front #(
        .PIXEL_COUNT (PIXEL_COUNT),
        .PIX_W       (PIX_W),
        .CMD_W       (CMD_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (rx_byte),
        .push     (push),
        .full     (full),
        .cmd_push (cmd_push),
        .cmd_data (cmd_wdata),
        .cmd_full (cmd_full)
    );

    // Queue commands between parser and engine
    lfcp_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_wdata),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_rdata),
        .empty   (cmd_empty)
    );

    // Execute commands and drive results
    lfcp_back #(
        .PIXEL_COUNT (PIXEL_COUNT),
        .PIX_W       (PIX_W),
        .CMD_W       (CMD_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_data    (cmd_rdata),
        .cmd_empty   (cmd_empty),
        .cmd_pop     (cmd_pop),
        .kind        (kind),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .host_byte   (host_byte),
        .delay_units (delay_units),
        .last        (last),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

/* src/lfcp_cmd_fifo.sv */
// ============================================================================
// LFCP command queue
// Small register queue that decouples the byte parser from the frame engine.
// ============================================================================
module lfcp_cmd_fifo
    import lfcp_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = CMD_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* src/lfcp_front.sv */
// ============================================================================
// LFCP byte parser
// Accepts received bytes, tracks handshake and frame pointers, and turns
// each meaningful byte into a command for the frame engine.
// ============================================================================
module lfcp_front
    import lfcp_pkg::*;
#(
    parameter int PIXEL_COUNT = PIXEL_COUNT_DEF,
    parameter int PIX_W       = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1,
    parameter int CMD_W       = OP_W + PIX_W + 2 + 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       rx_byte,
    input  logic             push,
    output logic             full,
    output logic             cmd_push,
    output logic [CMD_W-1:0] cmd_data,
    input  logic             cmd_full
);

    localparam logic [PIX_W-1:0] LAST_PIX = PIX_W'(PIXEL_COUNT - 1);

    typedef enum logic [2:0] {
        M_WAIT  = 3'b001,
        M_PARSE = 3'b010,
        M_DELAY = 3'b100
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic [PIX_W-1:0] pix_reg, pix_next;
    logic [1:0]       ch_reg, ch_next;
    op_t              cmd_op;
    logic             accept;

    assign full     = cmd_full;
    assign accept   = push && !cmd_full;
    assign cmd_data = {cmd_op, pix_reg, ch_reg, rx_byte};

    // Classify the byte and advance parser state
    always_comb
    begin
        mode_next = mode_reg;
        pix_next  = pix_reg;
        ch_next   = ch_reg;
        cmd_push  = 1'b0;
        cmd_op    = OP_WRITE;
        if (accept)
        begin
            case (mode_reg)
                M_WAIT:
                begin
                    if (rx_byte == BYTE_CONNECT)
                    begin
                        cmd_push  = 1'b1;
                        cmd_op    = OP_ACK;
                        mode_next = M_PARSE;
                    end
                end
                M_DELAY:
                begin
                    cmd_push  = 1'b1;
                    cmd_op    = OP_ECHO;
                    mode_next = M_PARSE;
                end
                M_PARSE:
                begin
                    if (rx_byte <= COLOR_MAX)
                    begin
                        cmd_push = 1'b1;
                        if (ch_reg == 2'd2)
                        begin
                            ch_next = 2'd0;
                            if (pix_reg == LAST_PIX)
                            begin
                                pix_next = '0;
                                cmd_op   = OP_WRITE_SHOW;
                            end
                            else
                            begin
                                pix_next = pix_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            ch_next = ch_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        case (rx_byte)
                            BYTE_SHOW:
                            begin
                                cmd_push = 1'b1;
                                cmd_op   = OP_SHOW;
                                pix_next = '0;
                                ch_next  = 2'd0;
                            end
                            BYTE_BLACK:
                            begin
                                cmd_push = 1'b1;
                                cmd_op   = OP_BLACK;
                            end
                            BYTE_DELAY:   mode_next = M_DELAY;
                            BYTE_CONNECT: mode_next = M_WAIT;
                            default:      ;
                        endcase
                    end
                end
                default: mode_next = M_WAIT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_WAIT;
            pix_reg  <= '0;
            ch_reg   <= 2'd0;
        end
        else
        begin
            mode_reg <= mode_next;
            pix_reg  <= pix_next;
            ch_reg   <= ch_next;
        end
    end

endmodule

/* src/lfcp_back.sv */
// ============================================================================
// LFCP frame engine
// Executes queued commands: writes the frame store, plays out frames one
// pixel at a time, and sends echo and acknowledge items to the output.
// ============================================================================
module lfcp_back
    import lfcp_pkg::*;
#(
    parameter int PIXEL_COUNT = PIXEL_COUNT_DEF,
    parameter int PIX_W       = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1,
    parameter int CMD_W       = OP_W + PIX_W + 2 + 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CMD_W-1:0] cmd_data,
    input  logic             cmd_empty,
    output logic             cmd_pop,
    output logic [1:0]       kind,
    output logic [3:0]       pixel_index,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic [7:0]       host_byte,
    output logic [7:0]       delay_units,
    output logic             last,
    output logic             empty,
    input  logic             pop
);

    localparam logic [PIX_W-1:0] LAST_PIX = PIX_W'(PIXEL_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } state_t;

    // Command fields
    op_t              c_op;
    logic [PIX_W-1:0] c_pix;
    logic [1:0]       c_ch;
    logic [7:0]       c_data;

    assign c_op   = op_t'(cmd_data[CMD_W-1 -: OP_W]);
    assign c_pix  = cmd_data[10 +: PIX_W];
    assign c_ch   = cmd_data[9:8];
    assign c_data = cmd_data[7:0];

    state_t           state_reg, state_next;
    logic [PIX_W-1:0] idx_reg, idx_next;
    logic             black_reg, black_next;
    logic             wr_en;

    // Frame store, one memory per channel, with written marks per entry
    logic [7:0]       mem_r [PIXEL_COUNT];
    logic [7:0]       mem_g [PIXEL_COUNT];
    logic [7:0]       mem_b [PIXEL_COUNT];
    logic [2:0]       vld_reg [PIXEL_COUNT];
    logic [7:0]       rd_r_reg;
    logic [7:0]       rd_g_reg;
    logic [7:0]       rd_b_reg;
    logic [2:0]       rd_vld_reg;

    // Output register
    logic             ov_reg, ov_next;
    kind_t            kind_reg, kind_next;
    logic [3:0]       opix_reg, opix_next;
    logic [7:0]       red_reg, red_next;
    logic [7:0]       green_reg, green_next;
    logic [7:0]       blue_reg, blue_next;
    logic [7:0]       host_reg, host_next;
    logic [7:0]       delay_reg, delay_next;
    logic             last_reg, last_next;
    logic             out_free;
    logic             load;

    assign out_free    = !ov_reg || pop;
    assign empty       = !ov_reg;
    assign kind        = kind_reg;
    assign pixel_index = opix_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign host_byte   = host_reg;
    assign delay_units = delay_reg;
    assign last        = last_reg;

    // Sequence commands and frame playout
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        black_next = black_reg;
        cmd_pop    = 1'b0;
        wr_en      = 1'b0;
        load       = 1'b0;
        kind_next  = kind_reg;
        opix_next  = opix_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        host_next  = host_reg;
        delay_next = delay_reg;
        last_next  = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    case (c_op)
                        OP_WRITE:
                        begin
                            wr_en   = 1'b1;
                            cmd_pop = 1'b1;
                        end
                        OP_WRITE_SHOW, OP_SHOW, OP_BLACK:
                        begin
                            wr_en      = (c_op == OP_WRITE_SHOW);
                            cmd_pop    = 1'b1;
                            idx_next   = '0;
                            black_next = (c_op == OP_BLACK);
                            state_next = S_READ;
                        end
                        OP_ECHO, OP_ACK:
                        begin
                            if (out_free)
                            begin
                                cmd_pop    = 1'b1;
                                load       = 1'b1;
                                kind_next  = (c_op == OP_ECHO) ? KIND_DELAY : KIND_ACK;
                                opix_next  = 4'd0;
                                red_next   = 8'd0;
                                green_next = 8'd0;
                                blue_next  = 8'd0;
                                host_next  = (c_op == OP_ECHO) ? c_data : BYTE_CONNECT;
                                delay_next = (c_op == OP_ECHO) ? c_data : 8'd0;
                                last_next  = 1'b1;
                            end
                        end
                        default: cmd_pop = 1'b1;
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    kind_next  = KIND_PIXEL;
                    opix_next  = 4'(idx_reg);
                    red_next   = (!black_reg && rd_vld_reg[0]) ? rd_r_reg : 8'd0;
                    green_next = (!black_reg && rd_vld_reg[1]) ? rd_g_reg : 8'd0;
                    blue_next  = (!black_reg && rd_vld_reg[2]) ? rd_b_reg : 8'd0;
                    host_next  = 8'd0;
                    delay_next = 8'd0;
                    last_next  = (idx_reg == LAST_PIX);
                    if (idx_reg == LAST_PIX)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold or drop the output item
    always_comb
    begin
        if (load)
        begin
            ov_next = 1'b1;
        end
        else if (pop)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            black_reg <= 1'b0;
            ov_reg    <= 1'b0;
            for (int i = 0; i < PIXEL_COUNT; i++)
            begin
                vld_reg[i] <= 3'b000;
            end
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            black_reg <= black_next;
            ov_reg    <= ov_next;
            if (wr_en)
            begin
                vld_reg[c_pix][c_ch] <= 1'b1;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        opix_reg  <= opix_next;
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        host_reg  <= host_next;
        delay_reg <= delay_next;
        last_reg  <= last_next;
    end

    // Frame store write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            case (c_ch)
                2'd0:    mem_r[c_pix] <= c_data;
                2'd1:    mem_g[c_pix] <= c_data;
                2'd2:    mem_b[c_pix] <= c_data;
                default: ;
            endcase
        end
    end

    // Frame store read port, registered
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            rd_r_reg   <= mem_r[idx_reg];
            rd_g_reg   <= mem_g[idx_reg];
            rd_b_reg   <= mem_b[idx_reg];
            rd_vld_reg <= vld_reg[idx_reg];
        end
    end

endmodule

/* src/lfcp_checker.sv */
// ============================================================================
// LFCP port checker
// Watches the top-level ports for result consistency over time.
// ============================================================================
module lfcp_checker
    import lfcp_pkg::*;
#(
    parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
)
(
    input logic       clk,
    input logic       rst_n,
    input logic [1:0] kind,
    input logic [3:0] pixel_index,
    input logic [7:0] host_byte,
    input logic [7:0] delay_units,
    input logic       last,
    input logic       empty,
    input logic       pop
);

    // Acknowledge carries the connect byte and closes its run
    a_ack_form: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_ACK) |-> (host_byte == BYTE_CONNECT && last))
        else $error("acknowledge item malformed");

    // Delay echo repeats the same byte on both fields and closes its run
    a_echo_form: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_DELAY) |-> (host_byte == delay_units && last))
        else $error("delay echo item malformed");

    // Frame ends on the final pixel
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_PIXEL && last) |->
            (pixel_index == 4'(PIXEL_COUNT - 1)))
        else $error("frame ended on wrong pixel");

    // Stalled item holds its kind and index
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(kind) && $stable(pixel_index)))
        else $error("stalled item changed");

endmodule

bind led_frame_command_parser lfcp_checker #(
    .PIXEL_COUNT (PIXEL_COUNT)
) u_lfcp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .kind        (kind),
    .pixel_index (pixel_index),
    .host_byte   (host_byte),
    .delay_units (delay_units),
    .last        (last),
    .empty       (empty),
    .pop         (pop)
);
